### hdl/tmrq_pkg.sv
// Shared types and constants for the timed message release queue.
// Used by tmrq_div and timed_message_release_queue; no dependencies.
`default_nettype none

package tmrq_pkg;

	// Request codes
	localparam logic [1:0] REQ_ENQUEUE = 2'd0;
	localparam logic [1:0] REQ_CLEAR   = 2'd1;
	localparam logic [1:0] REQ_TICK    = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_ENQUEUED = 2'd0;
	localparam logic [1:0] KIND_FULL     = 2'd1;
	localparam logic [1:0] KIND_CLEARED  = 2'd2;
	localparam logic [1:0] KIND_RELEASED = 2'd3;

	// Configuration register indexes
	localparam logic CFG_SAMPLE_RATE = 1'b0;
	localparam logic CFG_STALE_LIMIT = 1'b1;

	localparam int unsigned DEF_QUEUE_DEPTH = 64;
	localparam int unsigned MAX_RESULTS     = 64;
	localparam int unsigned RES_CNT_W       = 7;

	localparam int unsigned RATE_W  = 19;
	localparam int unsigned STALE_W = 16;
	localparam int unsigned OFF_W   = 31;
	localparam int unsigned TIME_W  = 32;

	// Offset * 1000 + rate/2 fits in 41 bits
	localparam int unsigned NUM_W   = 41;
	localparam int unsigned DCNT_W  = 6;
	localparam int unsigned MS_PER_S = 1000;

	localparam logic [RATE_W-1:0]  RATE_RESET  = 19'd44100;
	localparam logic [STALE_W-1:0] STALE_RESET = 16'd200;

	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [1:0]        len;
		logic [7:0]        b0;
		logic [7:0]        b1;
		logic [7:0]        b2;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SUM,
		ST_INS_RD,
		ST_INS_CHK,
		ST_TK_RD,
		ST_TK_CHK,
		ST_TK_END
	} state_t;

endpackage

`default_nettype wire

### hdl/tmrq_div.sv
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on tmrq_pkg for widths.
`default_nettype none

module tmrq_div import tmrq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [RATE_W-1:0] den,
	output logic                   done,
	output logic [NUM_W-1:0]       quo
);

	logic [RATE_W:0]     rem_q;
	logic [NUM_W-1:0]    quo_q;
	logic [RATE_W-1:0]   den_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic                run_q;
	logic                done_q;
	logic [RATE_W:0]     rem_sh;
	logic [RATE_W+1:0]   diff;

	// Trial subtraction for the next bit
	always_comb begin
		rem_sh = {rem_q[RATE_W-1:0], quo_q[NUM_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, den_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= DCNT_W'(NUM_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: numerator shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			if (!diff[RATE_W+1]) begin
				rem_q <= diff[RATE_W:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

### hdl/timed_message_release_queue.sv
// Top level of the timed message release queue: sequencer, queue memory, outputs.
// Depends on tmrq_pkg and tmrq_div.
`default_nettype none

// One request at a time: busy is high while a request is worked on, and its last
// result shows no later than the first cycle after busy falls.
// Enqueue runs the multiply, the due-time division (41 quotient bits, one per cycle
// in tmrq_div) and the saturating sum. It then walks back from the tail through the
// queue memory, moving each queued entry with a later due time up one slot, and
// places the new entry in the freed slot. A rejected enqueue ends after the sum.
// Clear never raises busy. A tick pops each due entry in turn, dropping stale ones,
// and stops at an entry that is not yet due, at an empty queue or once MAX_RESULTS
// entries are released.
// Each result shows for one cycle with result_valid and cannot be stalled;
// last marks the final result of a request. A tick with nothing released, and
// request code 3, give no result. The queue is a circular buffer of QUEUE_DEPTH
// entries; no clearing pass is needed after reset.
module timed_message_release_queue import tmrq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         req_type,
	input  wire logic [TIME_W-1:0]  start_ms,
	input  wire logic [OFF_W-1:0]   sample_offset,
	input  wire logic [1:0]         msg_length,
	input  wire logic [7:0]         msg_byte0,
	input  wire logic [7:0]         msg_byte1,
	input  wire logic [7:0]         msg_byte2,
	input  wire logic [TIME_W-1:0]  now_ms,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [RATE_W-1:0]  cfg_data,
	output logic                    result_valid,
	output logic [1:0]              result_kind,
	output logic [1:0]              out_length,
	output logic [7:0]              out_byte0,
	output logic [7:0]              out_byte1,
	output logic [7:0]              out_byte2,
	output logic [TIME_W-1:0]       due_ms,
	output logic                    last
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned PW = AW + 1;

	// Wrapped slot index of head + i
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [PW:0] s;
		s = {1'b0, PW'(h)} + (PW+1)'(i);
		if (s >= (PW+1)'(QUEUE_DEPTH))
			s = s - (PW+1)'(QUEUE_DEPTH);
		return s[AW-1:0];
	endfunction

	state_t state_q, state_d;

	logic [RATE_W-1:0]  sample_rate_q;
	logic [STALE_W-1:0] stale_limit_q;

	logic [TIME_W-1:0]  start_q;
	logic [OFF_W-1:0]   off_q;
	logic [TIME_W-1:0]  now_q;
	entry_t             new_q;
	logic [TIME_W-1:0]  due_q;

	logic [AW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      ins_i_q;
	logic [RES_CNT_W-1:0] n_q;
	entry_t             pend_q;
	logic               pend_v_q;

	entry_t             mem [QUEUE_DEPTH];
	entry_t             rdata_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	entry_t             mem_wdata;
	logic [AW-1:0]      mem_raddr;

	logic               div_go;
	logic               div_done;
	logic [NUM_W-1:0]   div_num;
	logic [NUM_W-1:0]   div_quo;
	logic [RATE_W-1:0]  rate_eff;

	logic [TIME_W+NUM_W-TIME_W+1:0] sum_w;
	logic [TIME_W-1:0]  due_sat;
	logic               full;
	logic               accept;
	logic               ins_later;
	logic               tk_due;
	logic [TIME_W-1:0]  late;
	logic               tk_emit;
	logic               tk_more;

	logic               res_load;
	logic [1:0]         res_kind;
	entry_t             res_entry;
	logic [TIME_W-1:0]  res_due;
	logic               res_last;

	logic               rv_q;
	logic [1:0]         kind_q;
	entry_t             oent_q;
	logic [TIME_W-1:0]  odue_q;
	logic               last_q;

	entry_t             new_in;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Incoming message with bytes past the length zeroed
	always_comb begin
		new_in.due = '0;
		new_in.len = msg_length;
		new_in.b0  = (msg_length >= 2'd1) ? msg_byte0 : 8'd0;
		new_in.b1  = (msg_length >= 2'd2) ? msg_byte1 : 8'd0;
		new_in.b2  = (msg_length == 2'd3) ? msg_byte2 : 8'd0;
	end

	// Due-time arithmetic
	always_comb begin
		rate_eff = (sample_rate_q == '0) ? RATE_W'(1) : sample_rate_q;
		div_num  = NUM_W'(off_q) * NUM_W'(MS_PER_S) + NUM_W'(rate_eff >> 1);
		sum_w    = {(NUM_W-TIME_W+2)'(0), start_q} + {2'b00, div_quo};
		due_sat  = (|sum_w[$high(sum_w):TIME_W]) ? '1 : sum_w[TIME_W-1:0];
		full     = (count_q >= CW'(QUEUE_DEPTH));
	end

	// Walk compares
	always_comb begin
		ins_later = (rdata_q.due > due_q);
		tk_due    = (rdata_q.due <= now_q);
		late      = now_q - rdata_q.due;
		tk_emit   = tk_due && (late < TIME_W'(stale_limit_q));
		tk_more   = (count_q != '0) && (n_q < RES_CNT_W'(MAX_RESULTS));
	end

	tmrq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (rate_eff),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req_type)
						REQ_ENQUEUE: state_d = ST_MUL;
						REQ_TICK:    state_d = ST_TK_RD;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL:     state_d = ST_DIV;
			ST_DIV:     state_d = div_done ? ST_SUM : ST_DIV;
			ST_SUM:     state_d = full ? ST_IDLE : ST_INS_RD;
			ST_INS_RD:  state_d = (ins_i_q == '0) ? ST_IDLE : ST_INS_CHK;
			ST_INS_CHK: state_d = ins_later ? ST_INS_RD : ST_IDLE;
			ST_TK_RD:   state_d = tk_more ? ST_TK_CHK : ST_TK_END;
			ST_TK_CHK:  state_d = tk_due ? ST_TK_RD : ST_TK_END;
			ST_TK_END:  state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		div_go    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = slot(head_q, ins_i_q);
		mem_wdata = new_q;
		mem_raddr = head_q;
		res_load  = 1'b0;
		res_kind  = KIND_ENQUEUED;
		res_entry = '0;
		res_due   = '0;
		res_last  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (start && req_type == REQ_CLEAR) begin
					res_load = 1'b1;
					res_kind = KIND_CLEARED;
				end
			end
			ST_MUL: div_go = 1'b1;
			ST_SUM: begin
				res_load = 1'b1;
				res_kind = full ? KIND_FULL : KIND_ENQUEUED;
				res_due  = due_sat;
			end
			ST_INS_RD: begin
				mem_raddr = slot(head_q, ins_i_q - 1'b1);
				if (ins_i_q == '0) begin
					mem_we = 1'b1;
				end
			end
			ST_INS_CHK: begin
				mem_we = 1'b1;
				if (ins_later) begin
					mem_wdata = rdata_q;
				end
			end
			ST_TK_CHK: begin
				if (tk_emit && pend_v_q) begin
					res_load  = 1'b1;
					res_kind  = KIND_RELEASED;
					res_entry = pend_q;
					res_due   = pend_q.due;
					res_last  = 1'b0;
				end
			end
			ST_TK_END: begin
				if (pend_v_q) begin
					res_load  = 1'b1;
					res_kind  = KIND_RELEASED;
					res_entry = pend_q;
					res_due   = pend_q.due;
				end
			end
			default: ;
		endcase
	end

	// Queue memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sample_rate_q <= RATE_RESET;
			stale_limit_q <= STALE_RESET;
			head_q        <= '0;
			count_q       <= '0;
			pend_v_q      <= 1'b0;
			rv_q          <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_q    <= res_load;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SAMPLE_RATE: sample_rate_q <= cfg_data;
					CFG_STALE_LIMIT: stale_limit_q <= cfg_data[STALE_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					pend_v_q <= 1'b0;
					if (start && req_type == REQ_CLEAR) begin
						count_q <= '0;
					end
				end
				ST_INS_RD: begin
					if (ins_i_q == '0) begin
						count_q <= count_q + 1'b1;
					end
				end
				ST_INS_CHK: begin
					if (!ins_later) begin
						count_q <= count_q + 1'b1;
					end
				end
				ST_TK_CHK: begin
					if (tk_due) begin
						head_q  <= slot(head_q, CW'(1));
						count_q <= count_q - 1'b1;
						if (tk_emit) begin
							pend_v_q <= 1'b1;
						end
					end
				end
				ST_TK_END: pend_v_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// Request payload and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_ms;
			off_q   <= sample_offset;
			now_q   <= now_ms;
			new_q   <= new_in;
			n_q     <= '0;
		end
		case (state_q)
			ST_SUM: begin
				due_q     <= due_sat;
				new_q.due <= due_sat;
				ins_i_q   <= count_q;
			end
			ST_INS_CHK: begin
				if (ins_later) begin
					ins_i_q <= ins_i_q - 1'b1;
				end
			end
			ST_TK_CHK: begin
				if (tk_emit) begin
					pend_q <= rdata_q;
					n_q    <= n_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			kind_q <= res_kind;
			oent_q <= res_entry;
			odue_q <= res_due;
			last_q <= res_last;
		end
	end

	assign result_valid = rv_q;
	assign result_kind  = kind_q;
	assign out_length   = oent_q.len;
	assign out_byte0    = oent_q.b0;
	assign out_byte1    = oent_q.b1;
	assign out_byte2    = oent_q.b2;
	assign due_ms       = odue_q;
	assign last         = last_q;

endmodule

`default_nettype wire
